>>> src/rhwm_pkg.sv
package rhwm_pkg;

    localparam int PIXEL_W = 16;
    localparam int CHAN_W  = 8;
    localparam int SUM_W   = 9;
    localparam int HREM_W  = 14;
    localparam int HQ_W    = 6;
    localparam int SREM_W  = 16;
    localparam int SDEN_W  = 9;
    localparam int SQ_W    = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LUM_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LUM_HIGH = 3'd5;

    localparam logic [CHAN_W-1:0] BOUND_LOW_RST  = 8'd0;
    localparam logic [CHAN_W-1:0] BOUND_HIGH_RST = 8'd255;

    localparam logic [CHAN_W-1:0] HUE_RED_WRAP = 8'd240;
    localparam logic [CHAN_W-1:0] HUE_RED      = 8'd0;
    localparam logic [CHAN_W-1:0] HUE_GREEN    = 8'd80;
    localparam logic [CHAN_W-1:0] HUE_BLUE     = 8'd160;
    localparam logic [CHAN_W-1:0] SCALE_TOP    = 8'd240;

    // luminance = floor(sum * 8 / 17) = (sum * 30848) >> 16 for sum up to 504
    localparam logic [14:0] LUM_RECIP = 15'd30848;
    localparam int          LUM_SHIFT = 16;

    // luminance > 120 exactly when sum >= 258; luminance == 0 when sum <= 2
    localparam logic [SUM_W-1:0] SAT_UPPER_SUM = 9'd258;
    localparam logic [SUM_W-1:0] BLACK_SUM_MAX = 9'd2;
    localparam logic [SUM_W-1:0] SAT_FULL      = 9'd510;

    typedef struct packed {
        logic [HREM_W-1:0] hrem;
        logic [CHAN_W-1:0] hden;
        logic [HQ_W-1:0]   hq;
        logic [SREM_W-1:0] srem;
        logic [SDEN_W-1:0] sden;
        logic [SQ_W-1:0]   sq;
        logic [CHAN_W-1:0] lum;
        logic [CHAN_W-1:0] base;
        logic              neg;
        logic              gray;
        logic              szero;
    } t_div;

    function automatic t_div hue_step(t_div d, int pos);
        logic [HREM_W:0] t;
        t_div o;
        o = d;
        t = (HREM_W+1)'(d.hden) << pos;
        if ({1'b0, d.hrem} >= t) begin
            o.hrem = d.hrem - t[HREM_W-1:0];
            o.hq[pos] = 1'b1;
        end
        return o;
    endfunction

    function automatic t_div sat_step(t_div d, int pos);
        logic [SREM_W:0] t;
        t_div o;
        o = d;
        t = (SREM_W+1)'(d.sden) << pos;
        if ({1'b0, d.srem} >= t) begin
            o.srem = d.srem - t[SREM_W-1:0];
            o.sq[pos] = 1'b1;
        end
        return o;
    endfunction

endpackage

>>> src/rgb565_hsl_window_match.sv
// Converts one RGB565 pixel per clock to hue, saturation and luminance on a 0..240 scale
// and flags whether all three lie strictly inside the six programmed bounds. Throughput is
// one word per cycle while the output is not stalled. Seven register stages, the first
// loaded at the accept edge, lie between input accept and output valid: expand, divider
// setup, four restoring divider stages (two saturation and, in the first three, two hue
// quotient bits each), compose. Stages advance independently, so bubbles collapse under
// output backpressure. Write the bound registers only while the pipeline is empty.
module rgb565_hsl_window_match (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [rhwm_pkg::PIXEL_W-1:0]      i_pixel,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [rhwm_pkg::CHAN_W-1:0]       o_hue,
    output logic [rhwm_pkg::CHAN_W-1:0]       o_saturation,
    output logic [rhwm_pkg::CHAN_W-1:0]       o_luminance,
    output logic                              o_in_window,
    input  logic                              i_cfg_we,
    input  logic [rhwm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rhwm_pkg::CHAN_W-1:0]       i_cfg_data
);
    import rhwm_pkg::*;

    localparam int NSTG = 7;
    localparam int NDIV = 4;

    logic [CHAN_W-1:0] r_hue_low, r_hue_high, r_sat_low, r_sat_high, r_lum_low, r_lum_high;

    logic [NSTG:1] r_v;
    logic [NSTG:1] adv;

    logic [CHAN_W-1:0] r1_n, r1_dif, r1_base;
    logic [SUM_W-1:0]  r1_sum;
    logic              r1_neg;
    logic [CHAN_W-1:0] n1_n, n1_dif, n1_base;
    logic [SUM_W-1:0]  n1_sum;
    logic              n1_neg;

    t_div r_div [0:NDIV];
    t_div n_div [0:NDIV];

    logic [CHAN_W-1:0] r_hue, r_sat, r_lum;
    logic              r_win;
    logic [CHAN_W-1:0] n_hue, n_sat, n_lum;
    logic              n_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_low  <= BOUND_LOW_RST;
            r_hue_high <= BOUND_HIGH_RST;
            r_sat_low  <= BOUND_LOW_RST;
            r_sat_high <= BOUND_HIGH_RST;
            r_lum_low  <= BOUND_LOW_RST;
            r_lum_high <= BOUND_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HUE_LOW:  r_hue_low  <= i_cfg_data;
                REG_HUE_HIGH: r_hue_high <= i_cfg_data;
                REG_SAT_LOW:  r_sat_low  <= i_cfg_data;
                REG_SAT_HIGH: r_sat_high <= i_cfg_data;
                REG_LUM_LOW:  r_lum_low  <= i_cfg_data;
                REG_LUM_HIGH: r_lum_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance a stage when it is empty or the next one advances
    always_comb begin
        adv[NSTG] = !r_v[NSTG] || i_out_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_in_ready = adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[1]) begin
                r_v[1] <= i_in_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: channel expand, max/min, hue sector
    always_comb begin
        logic [CHAN_W-1:0] r, g, b, mx, mn;
        r = {i_pixel[15:11], 3'b000};
        g = {i_pixel[10:5], 2'b00};
        b = {i_pixel[4:0], 3'b000};
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        n1_dif = mx - mn;
        n1_sum = SUM_W'(mx) + SUM_W'(mn);
        if (mx == r) begin
            n1_neg  = g < b;
            n1_n    = n1_neg ? b - g : g - b;
            n1_base = n1_neg ? HUE_RED_WRAP : HUE_RED;
        end else if (mx == g) begin
            n1_neg  = b < r;
            n1_n    = n1_neg ? r - b : b - r;
            n1_base = HUE_GREEN;
        end else begin
            n1_neg  = r < g;
            n1_n    = n1_neg ? g - r : r - g;
            n1_base = HUE_BLUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_n    <= n1_n;
            r1_dif  <= n1_dif;
            r1_base <= n1_base;
            r1_sum  <= n1_sum;
            r1_neg  <= n1_neg;
        end
    end

    // stage 2: scale numerators, luminance, saturation denominator
    always_comb begin
        logic [23:0] lprod;
        lprod = 24'(r1_sum) * 24'(LUM_RECIP);
        n_div[0] = '0;
        n_div[0].hrem  = (HREM_W'(r1_n) << 5) + (HREM_W'(r1_n) << 3);
        n_div[0].hden  = r1_dif;
        n_div[0].srem  = (SREM_W'(r1_dif) << 8) - (SREM_W'(r1_dif) << 4);
        n_div[0].sden  = (r1_sum >= SAT_UPPER_SUM) ? SAT_FULL - r1_sum : r1_sum;
        n_div[0].lum   = lprod[LUM_SHIFT +: CHAN_W];
        n_div[0].base  = r1_base;
        n_div[0].neg   = r1_neg;
        n_div[0].gray  = r1_dif == '0;
        n_div[0].szero = (r1_dif == '0) || (r1_sum <= BLACK_SUM_MAX);
    end

    // stages 3..6: two saturation quotient bits per stage, two hue quotient bits in stages 3..5
    for (genvar k = 1; k <= NDIV; k++) begin : g_div
        always_comb begin
            t_div d;
            d = r_div[k-1];
            d = sat_step(d, SQ_W - 1 - 2 * (k - 1));
            d = sat_step(d, SQ_W - 2 - 2 * (k - 1));
            if (2 * k <= HQ_W) begin
                d = hue_step(d, HQ_W - 1 - 2 * (k - 1));
                d = hue_step(d, HQ_W - 2 - 2 * (k - 1));
            end
            n_div[k] = d;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= NDIV; k++) begin
            if (adv[k+2]) begin
                r_div[k] <= n_div[k];
            end
        end
    end

    // stage 7: compose hue, window compare
    always_comb begin
        t_div d;
        d = r_div[NDIV];
        if (d.gray) begin
            n_hue = '0;
        end else if (d.neg) begin
            n_hue = d.base - CHAN_W'(d.hq);
        end else begin
            n_hue = d.base + CHAN_W'(d.hq);
        end
        n_sat = d.szero ? '0 : d.sq;
        n_lum = d.lum;
        n_win = (n_hue > r_hue_low) && (n_hue < r_hue_high) &&
                (n_sat > r_sat_low) && (n_sat < r_sat_high) &&
                (n_lum > r_lum_low) && (n_lum < r_lum_high);
    end

    always_ff @(posedge i_clk) begin
        if (adv[NSTG]) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_lum <= n_lum;
            r_win <= n_win;
        end
    end

    assign o_out_valid  = r_v[NSTG];
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_luminance  = r_lum;
    assign o_in_window  = r_win;

`ifndef SYNTHESIS
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hue <= SCALE_TOP) && (o_saturation <= SCALE_TOP) &&
                        (o_luminance <= SCALE_TOP))
        else $error("hsl result above scale top");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_v) && !i_out_ready |-> !o_in_ready)
        else $error("input accepted into a full stalled pipeline");

    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NSTG-1] && !adv[NSTG-1] |=> r_v[NSTG-1])
        else $error("stalled item dropped from divider stage");
`endif

endmodule
